### sv/assert_macros.svh
// Assertion macros for the slot mount map RTL.
// Included by the top level, which checks its own sequencing; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) else $error(msg);

`endif

### sv/dsmm_pkg.sv
// Shared constants and types for the debounced slot mount map.
// Used by the order walker and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dsmm_pkg;

  // Largest slot count and the width of one packed slot or owner field.
  localparam int SLOT_CAP  = 8;
  localparam int DEF_SLOTS = 8;
  localparam int FIELD_W   = 4;

  typedef logic [FIELD_W-1:0] field_t;

  // Marker for an empty slot or an unmounted controller.
  localparam field_t EMPTY = 4'hF;

  // Register defaults and the reset value of the last wanted set.
  localparam logic [15:0] DEF_DEBOUNCE = 16'd2000;
  localparam logic [19:0] DEF_IDLE     = 20'd60000;
  localparam logic [7:0]  WANT_RESET   = 8'hFF;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE     = 2'd3;

  // Control into and status out of the order walker.
  typedef struct packed {
    logic start;
  } walk_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } walk_sts_t;

endpackage

`default_nettype wire

### sv/dsmm_order.sv
// Order walker: builds the new slot list from a wanted set, survivors first.
// Depends on dsmm_pkg for the field type, the empty marker and control structs.
`timescale 1ns / 1ps
`default_nettype none

module dsmm_order #(
  parameter int SLOTS = dsmm_pkg::DEF_SLOTS,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dsmm_pkg::walk_ctl_t                ctl,
  output dsmm_pkg::walk_sts_t                sts,
  input  logic [SLOTS-1:0]                   want,
  input  logic [CW-1:0]                      budget,
  input  logic [CW-1:0]                      count,
  input  dsmm_pkg::field_t [SLOTS-1:0]       owners,
  output dsmm_pkg::field_t [SLOTS-1:0]       list,
  output logic [CW-1:0]                      len
);

  logic             busy;
  logic             done;
  logic             new_phase;
  logic [IW-1:0]    idx;
  logic [SLOTS-1:0] taken;

  dsmm_pkg::field_t cand;
  logic [IW-1:0]    cidx;
  logic             in_range;
  logic             hit;
  logic             last_step;

  // One candidate per cycle: old slots in order, then controllers ascending.
  always_comb begin
    if (new_phase) begin
      cand     = dsmm_pkg::field_t'(idx);
      in_range = 1'b1;
    end else begin
      cand     = owners[idx];
      in_range = (CW'(idx) < count) && (cand < dsmm_pkg::field_t'(SLOTS));
    end
    cidx      = cand[IW-1:0];
    hit       = in_range && (len < budget) && want[cidx] && !taken[cidx];
    last_step = (idx == IW'(SLOTS - 1));
  end

  assign sts.busy = busy;
  assign sts.done = done;

  // Sequencer for the two passes over the slots.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && last_step && new_phase) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Append the accepted candidate and step the index.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      new_phase <= 1'b0;
      idx       <= '0;
      len       <= '0;
      taken     <= '0;
      list      <= {SLOTS{dsmm_pkg::EMPTY}};
    end else if (busy) begin
      if (hit) begin
        list[len[IW-1:0]] <= cand;
        len               <= len + 1'b1;
        taken[cidx]       <= 1'b1;
      end
      if (last_step) begin
        new_phase <= 1'b1;
        idx       <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/debounced_slot_mount_map.sv
// Top level of the debounced slot mount map; uses dsmm_pkg and dsmm_order.
// A disabled tick goes from the accepting edge straight to the result state; an enabled
// tick passes the wanted-set check and, if the set is unchanged, the debounce check; a
// rebuild, or a tick whose set has held long enough, runs the walker, commits, then outputs.
// A new request is taken only back in idle, once the result has been loaded; an output
// stall holds it in the result state. Synchronous reset restores defaults at once.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module debounced_slot_mount_map #(
  parameter int SLOTS = dsmm_pkg::DEF_SLOTS,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration writes.
  input  logic                            cfg_we,
  input  logic [dsmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsmm_pkg::CFG_DATA_W-1:0] cfg_data,
  // Request stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [71:0]                     s_tdata,  // now_ms, connected_mask, last_input_ms
  input  logic                            s_tuser,  // func
  // Result stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [71:0]                     m_tdata,  // mount_count, slot_owner_packed,
                                                    // owner_slot_packed, zero fill
  output logic                            m_tuser   // reenumerate
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_IDLECHK = 6'b000010,
    ST_DEBCHK  = 6'b000100,
    ST_WALK    = 6'b001000,
    ST_COMMIT  = 6'b010000,
    ST_OUT     = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers.
  logic          enable;
  logic [CW-1:0] budget;
  logic [15:0]   debounce;
  logic [19:0]   idle_lim;

  // Map and debounce state.
  dsmm_pkg::field_t [SLOTS-1:0] slot_owner;
  dsmm_pkg::field_t [SLOTS-1:0] owner_slot;
  logic [CW-1:0]                mounted;
  logic [7:0]                   last_wanted;
  logic [31:0]                  stable_start;

  // Latched request and working values.
  logic             func_r;
  logic [31:0]      now_r;
  logic [SLOTS-1:0] conn_r;
  logic [31:0]      last_in_r;
  logic [SLOTS-1:0] want_r;
  logic             reen;

  // Walker connections.
  dsmm_pkg::walk_ctl_t          ctl;
  dsmm_pkg::walk_sts_t          sts;
  dsmm_pkg::field_t [SLOTS-1:0] walk_list;
  logic [CW-1:0]                walk_len;

  logic             in_fire;
  logic             out_free;
  logic [31:0]      op_b;
  logic [31:0]      op_lim;
  logic [31:0]      diff;
  logic             diff_ge;
  logic             is_idle;
  logic [SLOTS-1:0] cur;
  logic [SLOTS-1:0] want_c;
  logic [SLOTS-1:0] new_set;
  dsmm_pkg::field_t [SLOTS-1:0] new_slot;
  logic [31:0]      so_pack;
  logic [31:0]      os_pack;
  logic [CW-1:0]    budget_wr;
  logic [3:0]       budget_raw;

  assign in_fire  = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Shared time unit: wrapping difference against the idle or debounce limit.
  always_comb begin
    if (state == ST_DEBCHK) begin
      op_b   = stable_start;
      op_lim = 32'(debounce);
    end else begin
      op_b   = last_in_r;
      op_lim = 32'(idle_lim);
    end
    diff    = now_r - op_b;
    diff_ge = (diff >= op_lim);
    is_idle = (last_in_r == 32'd0) || diff_ge;
  end

  // Mounted set, wanted set, and the inverse map of the new list.
  always_comb begin
    for (int c = 0; c < SLOTS; c++) begin
      cur[c] = (owner_slot[c] != dsmm_pkg::EMPTY);
    end
    want_c = is_idle ? conn_r : (conn_r | cur);
    for (int c = 0; c < SLOTS; c++) begin
      new_set[c]  = 1'b0;
      new_slot[c] = dsmm_pkg::EMPTY;
      for (int i = 0; i < SLOTS; i++) begin
        if (walk_list[i] == dsmm_pkg::field_t'(c)) begin
          new_set[c]  = 1'b1;
          new_slot[c] = dsmm_pkg::field_t'(i);
        end
      end
    end
  end

  // Packed views of both directions of the map, empty beyond the slot count.
  for (genvar g = 0; g < dsmm_pkg::SLOT_CAP; g++) begin : g_pack
    if (g < SLOTS) begin : g_used
      assign so_pack[4*g +: 4] = slot_owner[g];
      assign os_pack[4*g +: 4] = owner_slot[g];
    end else begin : g_unused
      assign so_pack[4*g +: 4] = dsmm_pkg::EMPTY;
      assign os_pack[4*g +: 4] = dsmm_pkg::EMPTY;
    end
  end

  // Slot budget write is clamped to one through the slot count.
  always_comb begin
    budget_raw = cfg_data[3:0];
    priority if (budget_raw == 4'd0) begin
      budget_wr = CW'(1);
    end else if (budget_raw > 4'(SLOTS)) begin
      budget_wr = CW'(SLOTS);
    end else begin
      budget_wr = budget_raw[CW-1:0];
    end
  end

  // Start the walker on a rebuild or once the wanted set has held long enough.
  assign ctl.start = (in_fire && s_tuser) || ((state == ST_DEBCHK) && diff_ge);

  dsmm_order #(.SLOTS(SLOTS)) u_order (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sts    (sts),
    .want   (want_r),
    .budget (budget),
    .count  (mounted),
    .owners (slot_owner),
    .list   (walk_list),
    .len    (walk_len)
  );

  // Sequencer, map state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      enable       <= 1'b0;
      budget       <= CW'(SLOTS);
      debounce     <= dsmm_pkg::DEF_DEBOUNCE;
      idle_lim     <= dsmm_pkg::DEF_IDLE;
      slot_owner   <= {SLOTS{dsmm_pkg::EMPTY}};
      owner_slot   <= {SLOTS{dsmm_pkg::EMPTY}};
      mounted      <= '0;
      last_wanted  <= dsmm_pkg::WANT_RESET;
      stable_start <= 32'd0;
      m_tvalid     <= 1'b0;
    end else begin
      // The result valid rises when a result is loaded and falls once it is taken.
      if ((state == ST_OUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            priority if (s_tuser) begin
              state <= ST_WALK;
            end else if (enable) begin
              state <= ST_IDLECHK;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_IDLECHK: begin
          if (8'(want_c) != last_wanted) begin
            last_wanted  <= 8'(want_c);
            stable_start <= now_r;
            state        <= ST_OUT;
          end else begin
            state <= ST_DEBCHK;
          end
        end
        ST_DEBCHK: begin
          state <= diff_ge ? ST_WALK : ST_OUT;
        end
        ST_WALK: begin
          if (sts.done) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (func_r || (new_set != cur)) begin
            slot_owner <= walk_list;
            owner_slot <= new_slot;
            mounted    <= walk_len;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // Register writes; a write of the enable register also empties the map.
      if (cfg_we) begin
        unique case (cfg_index)
          dsmm_pkg::REG_ENABLE: begin
            enable     <= cfg_data[0];
            slot_owner <= {SLOTS{dsmm_pkg::EMPTY}};
            owner_slot <= {SLOTS{dsmm_pkg::EMPTY}};
            mounted    <= '0;
          end
          dsmm_pkg::REG_BUDGET:   budget   <= budget_wr;
          dsmm_pkg::REG_DEBOUNCE: debounce <= cfg_data[15:0];
          dsmm_pkg::REG_IDLE:     idle_lim <= cfg_data[19:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Request capture, wanted set, flag and result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r    <= s_tuser;
      now_r     <= s_tdata[31:0];
      conn_r    <= s_tdata[32 +: SLOTS];
      last_in_r <= s_tdata[71:40];
      want_r    <= s_tdata[32 +: SLOTS];
      reen      <= 1'b0;
    end
    if (state == ST_IDLECHK) begin
      want_r <= want_c;
    end
    if (state == ST_COMMIT) begin
      reen <= !func_r && (new_set != cur);
    end
    if ((state == ST_OUT) && out_free) begin
      m_tdata <= {4'd0, os_pack, so_pack, 4'(mounted)};
      m_tuser <= reen;
    end
  end

  `ASSERT_CLK(a_done_in_walk, clk, rst, sts.done |-> (state == ST_WALK), "done outside walk")
  `ASSERT_CLK(a_ready_walker_idle, clk, rst, s_tready |-> !sts.busy, "ready while walker busy")
  `ASSERT_CLK(a_commit_to_out, clk, rst, (state == ST_COMMIT) |=> (state == ST_OUT), "no result")
  `ASSERT_NEVER(a_count_range, clk, rst, mounted > CW'(SLOTS), "mounted count beyond slots")

endmodule

`default_nettype wire
